// ===== rtl/hrps_pkg.sv =====
// Shared constants and types for the half-rate record and replay pitch shifter.
`timescale 1ns / 1ps

package hrps_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CFG_W = 15;
   localparam int CSR_INDEX_W = 2;

   localparam int STORE_DEPTH_DEF = 16384;

   localparam logic [CFG_W-1:0] FIRST_WAIT_RST = 15'd32000;
   localparam logic [CFG_W-1:0] LATER_WAIT_RST = 15'd24000;
   localparam logic [CFG_W-1:0] RECORD_LENGTH_RST = 15'd16000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FIRST_WAIT    = 2'd0,
      REG_LATER_WAIT    = 2'd1,
      REG_RECORD_LENGTH = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] first_wait;
      logic [CFG_W-1:0] later_wait;
      logic [CFG_W-1:0] record_length;
   } cfg_type;

endpackage

// ===== rtl/hrps_req_if.sv =====
// Input channel: one stereo sample pair per word.
`timescale 1ns / 1ps

interface hrps_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [hrps_pkg::SAMPLE_W-1:0] left_in;
   logic signed [hrps_pkg::SAMPLE_W-1:0] right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink (input valid, input left_in, input right_in, output ready);
endinterface

// ===== rtl/hrps_rsp_if.sv =====
// Result channel: one stereo sample pair per word.
`timescale 1ns / 1ps

interface hrps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [hrps_pkg::SAMPLE_W-1:0] left_out;
   logic signed [hrps_pkg::SAMPLE_W-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/hrps_csr_if.sv =====
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface hrps_csr_if;
   logic                                valid;
   logic                                ready;
   logic [hrps_pkg::CSR_INDEX_W-1:0]    index;
   logic [hrps_pkg::CFG_W-1:0]          data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/hrps_csr_regs.sv =====
// Configuration registers: wait times and record length.
`timescale 1ns / 1ps

module hrps_csr_regs (
   input  logic               clock,
   input  logic               reset,
   hrps_csr_if.sink           csr,
   output hrps_pkg::cfg_type  cfg
);

   hrps_pkg::cfg_type cfg_ff;
   hrps_pkg::cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         // An index beyond the register list leaves everything as it is.
         unique case (hrps_pkg::reg_index_type'(csr.index))
            hrps_pkg::REG_FIRST_WAIT:    cfg_in.first_wait = csr.data;
            hrps_pkg::REG_LATER_WAIT:    cfg_in.later_wait = csr.data;
            hrps_pkg::REG_RECORD_LENGTH: cfg_in.record_length = csr.data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_wait <= hrps_pkg::FIRST_WAIT_RST;
         cfg_ff.later_wait <= hrps_pkg::LATER_WAIT_RST;
         cfg_ff.record_length <= hrps_pkg::RECORD_LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/hrps_record_store.sv =====
// Record memory: one write port and one registered read port.
`timescale 1ns / 1ps

module hrps_record_store #(
   parameter int STORE_DEPTH = hrps_pkg::STORE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic [$clog2(STORE_DEPTH)-1:0]      rd_addr,
   output logic [hrps_pkg::SAMPLE_W-1:0]       rd_data,
   input  logic                                wr_en,
   input  logic [$clog2(STORE_DEPTH)-1:0]      wr_addr,
   input  logic [hrps_pkg::SAMPLE_W-1:0]       wr_data
);

   logic [hrps_pkg::SAMPLE_W-1:0] mem [STORE_DEPTH];
   logic [hrps_pkg::SAMPLE_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A read at the address being written returns the old entry.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/hrps_sequencer.sv =====
// Silence counter, replay and record pointers, and the half-rate record toggle.
`timescale 1ns / 1ps

module hrps_sequencer #(
   parameter int STORE_DEPTH = hrps_pkg::STORE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  hrps_pkg::cfg_type               cfg,
   output logic [$clog2(STORE_DEPTH)-1:0]  rd_addr,
   output logic                            wr_en,
   output logic [$clog2(STORE_DEPTH)-1:0]  wr_addr,
   output logic                            play
);

   localparam int AddrW = $clog2(STORE_DEPTH);
   localparam int LenW = $clog2(STORE_DEPTH + 1);
   localparam int CmpW = (LenW > hrps_pkg::CFG_W) ? LenW : hrps_pkg::CFG_W;
   localparam logic [CmpW-1:0] DepthC = CmpW'(STORE_DEPTH);

   logic [hrps_pkg::CFG_W-1:0] count_ff, count_in;
   logic [AddrW-1:0]           play_ptr_ff, play_ptr_in;
   logic [AddrW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic                       odd_ff, odd_in;
   logic                       played_ff, played_in;

   logic [CmpW-1:0]            len_ext;
   logic [CmpW-1:0]            eff_len;
   logic [hrps_pkg::CFG_W-1:0] wait_len;
   logic                       silent;
   logic [AddrW-1:0]           play_cur;
   logic [AddrW-1:0]           wr_cur;
   logic [CmpW-1:0]            play_inc;
   logic [CmpW-1:0]            wr_inc;
   logic                       play_wrap;
   logic                       wr_wrap;

   always_comb begin
      len_ext = CmpW'(cfg.record_length);
      if (len_ext == '0) begin
         eff_len = CmpW'(1);
      end else if (len_ext > DepthC) begin
         eff_len = DepthC;
      end else begin
         eff_len = len_ext;
      end

      wait_len = played_ff ? cfg.later_wait : cfg.first_wait;
      silent = count_ff < wait_len;

      // A pointer left past a lowered length starts over at zero.
      play_cur = (CmpW'(play_ptr_ff) >= eff_len) ? '0 : play_ptr_ff;
      wr_cur = (CmpW'(wr_ptr_ff) >= eff_len) ? '0 : wr_ptr_ff;
      play_inc = CmpW'(play_cur) + CmpW'(1);
      wr_inc = CmpW'(wr_cur) + CmpW'(1);
      play_wrap = play_inc >= eff_len;
      wr_wrap = wr_inc >= eff_len;

      count_in = count_ff;
      play_ptr_in = play_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      played_in = played_ff;
      odd_in = ~odd_ff;

      if (silent) begin
         count_in = count_ff + hrps_pkg::CFG_W'(1);
      end else begin
         played_in = 1'b1;
         play_ptr_in = play_wrap ? '0 : play_inc[AddrW-1:0];
         if (play_wrap) begin
            count_in = '0;
         end
      end

      if (!odd_ff) begin
         wr_ptr_in = wr_wrap ? '0 : wr_inc[AddrW-1:0];
      end
   end

   assign rd_addr = play_cur;
   assign wr_addr = wr_cur;
   assign wr_en = step && !odd_ff;
   assign play = !silent;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         play_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         odd_ff <= 1'b0;
         played_ff <= 1'b0;
      end else if (step) begin
         count_ff <= count_in;
         play_ptr_ff <= play_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         odd_ff <= odd_in;
         played_ff <= played_in;
      end
   end

endmodule

// ===== rtl/halfrate_record_replay_pitch_shift_core.sv =====
// Top level of the half-rate record and full-rate replay pitch shifter.
//
//   Channel  Dir  Handshake      Word
//   req      in   valid/ready    left_in, right_in (signed 16 bit each)
//   rsp      out  valid/ready    left_out, right_out (signed 16 bit each)
//   csr      in   valid/ready    index (2 bit), data (15 bit)
//
// A word accepted on req appears on rsp in the next cycle; while rsp is ready,
// one word per cycle is sustained by the single registered record memory read.
// The memory read register doubles as the result register, so a word is taken
// whenever the result slot is empty or being drained in the same cycle.
// Reset is synchronous; it clears the counters, pointers and the result slot.
// The record memory is not cleared. csr is always ready.
`timescale 1ns / 1ps

module halfrate_record_replay_pitch_shift_core #(
   parameter int STORE_DEPTH = hrps_pkg::STORE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   hrps_req_if.sink   req,
   hrps_rsp_if.source rsp,
   hrps_csr_if.sink   csr
);

   localparam int AddrW = $clog2(STORE_DEPTH);

   hrps_pkg::cfg_type             cfg;
   logic                          accept;
   logic [AddrW-1:0]              rd_addr;
   logic [AddrW-1:0]              wr_addr;
   logic                          wr_en;
   logic                          play;
   logic [hrps_pkg::SAMPLE_W-1:0] rd_data;

   logic                          valid_ff;
   logic                          play_ff;
   logic [hrps_pkg::SAMPLE_W-1:0] right_ff;

   assign req.ready = !valid_ff || rsp.ready;
   assign accept = req.valid && req.ready;

   hrps_csr_regs u_csr_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   hrps_sequencer #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_sequencer (
      .clock   (clock),
      .reset   (reset),
      .step    (accept),
      .cfg     (cfg),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .play    (play)
   );

   hrps_record_store #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_record_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req.left_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         play_ff <= play;
         right_ff <= req.right_in;
      end
   end

   assign rsp.valid = valid_ff;
   assign rsp.left_out = play_ff ? rd_data : '0;
   assign rsp.right_out = right_ff;

endmodule
